// ----- hw/rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [7:0]  CH_NL      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_BS      = 8'h08;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  COLOR_RST  = 8'h07;
  localparam logic [15:0] CELL_RST   = 16'h0720;

  typedef enum logic [1:0] {
    KIND_PUT = 2'd0,
    KIND_SET = 2'd1,
    KIND_CLR = 2'd2,
    KIND_RD  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_PUT = 3'd0,
    OP_NL  = 3'd1,
    OP_CR  = 3'd2,
    OP_BS  = 3'd3,
    OP_TAB = 3'd4,
    OP_SET = 3'd5,
    OP_CLR = 3'd6,
    OP_RD  = 3'd7
  } op_e;

  // classified command handed from front to back
  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              in_range;
  } cmd_t;

  // back to front status
  typedef struct packed {
    logic take;
    logic init_busy;
  } back_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [1:0]          kind_i,
  input  wire logic [7:0]          char_code_i,
  input  wire logic [6:0]          col_in_i,
  input  wire logic [4:0]          row_in_i,
  input  wire tcw_pkg::back_stat_t stat_i,
  output logic                     cmd_valid_o,
  output tcw_pkg::cmd_t            cmd_o
);
  import tcw_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cls;
  logic       acc, take;

  // classify the incoming item
  always_comb begin
    cls.ch       = char_code_i;
    cls.col      = col_in_i;
    cls.row      = row_in_i;
    cls.in_range = (32'(col_in_i) < COLUMNS) && (32'(row_in_i) < ROWS);
    case (kind_e'(kind_i))
      KIND_PUT: begin
        case (char_code_i)
          CH_NL:   cls.op = OP_NL;
          CH_CR:   cls.op = OP_CR;
          CH_BS:   cls.op = OP_BS;
          CH_TAB:  cls.op = OP_TAB;
          default: cls.op = OP_PUT;
        endcase
      end
      KIND_SET: cls.op = OP_SET;
      KIND_CLR: cls.op = OP_CLR;
      KIND_RD:  cls.op = OP_RD;
      default:  cls.op = OP_RD;
    endcase
  end

  assign full        = (cnt_q == 2'd2) || stat_i.init_busy;
  assign acc         = push && !full;
  assign take        = stat_i.take && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = acc ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = take ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(acc) - 2'(take);
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                text_color_we_i,
  input  wire logic [7:0]          text_color_i,
  input  wire logic                cmd_valid_i,
  input  wire tcw_pkg::cmd_t       cmd_i,
  output tcw_pkg::back_stat_t      stat_o,
  output logic                     empty,
  input  wire logic                pop,
  output logic [15:0]              cell_value_o,
  output logic [4:0]               cursor_row_o,
  output logic [6:0]               cursor_col_o
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [5:0] {
    ST_INIT = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_RDW  = 6'b000100,
    ST_SCR  = 6'b001000,
    ST_SCW  = 6'b010000,
    ST_FILL = 6'b100000
  } state_e;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_q;

  state_e      state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic        clr_q, clr_d;
  logic [7:0]  color_q;
  logic [4:0]  row_q, row_d;
  logic [6:0]  col_q, col_d;
  logic        ov_q, ov_d;
  logic [15:0] ocell_q, ocell_d;
  logic [4:0]  orow_q, orow_d;
  logic [6:0]  ocol_q, ocol_d;

  logic          we;
  logic [AW-1:0] waddr, raddr, cur_addr, cmd_addr;
  logic [15:0]   wdata, blank;
  logic          slot_free, start, emit, nl;
  logic [7:0]    stop;

  assign blank     = {color_q, CH_SPACE};
  assign cur_addr  = AW'(32'(row_q) * COLUMNS + 32'(col_q));
  assign cmd_addr  = AW'(32'(cmd_i.row) * COLUMNS + 32'(cmd_i.col));
  assign slot_free = !ov_q || pop;
  assign start     = (state_q == ST_IDLE) && cmd_valid_i && slot_free;
  assign stop      = ({1'b0, col_q} + 8'd4) & ~8'd3;

  assign stat_o.take      = start;
  assign stat_o.init_busy = (state_q == ST_INIT);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    clr_d   = clr_q;
    row_d   = row_q;
    col_d   = col_q;
    we      = 1'b0;
    waddr   = cur_addr;
    wdata   = blank;
    raddr   = cmd_addr;
    emit    = 1'b0;
    nl      = 1'b0;
    ocell_d = 16'd0;
    case (state_q)
      ST_INIT: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = CELL_RST;
        idx_d = idx_q + AW'(1);
        if (idx_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (cmd_i.op)
            OP_PUT: begin
              we    = 1'b1;
              wdata = {color_q, cmd_i.ch};
              if (32'(col_q) + 1 >= COLUMNS) begin
                nl = 1'b1;
              end else begin
                col_d = col_q + 7'd1;
                emit  = 1'b1;
              end
            end
            OP_NL: nl = 1'b1;
            OP_CR: begin
              col_d = '0;
              emit  = 1'b1;
            end
            OP_BS: begin
              emit = 1'b1;
              if (col_q != '0) begin
                col_d = col_q - 7'd1;
                we    = 1'b1;
                waddr = cur_addr - AW'(1);
              end
            end
            OP_TAB: begin
              if (32'(stop) >= COLUMNS) begin
                nl = 1'b1;
              end else begin
                col_d = stop[6:0];
                emit  = 1'b1;
              end
            end
            OP_SET: begin
              emit = 1'b1;
              if (cmd_i.in_range) begin
                row_d = cmd_i.row;
                col_d = cmd_i.col;
              end
            end
            OP_CLR: begin
              idx_d   = '0;
              clr_d   = 1'b1;
              state_d = ST_FILL;
            end
            OP_RD: begin
              if (cmd_i.in_range) begin
                state_d = ST_RDW;
              end else begin
                emit = 1'b1;
              end
            end
            default: emit = 1'b1;
          endcase
          // newline: next row, or scroll from the bottom row
          if (nl) begin
            col_d = '0;
            if (32'(row_q) == ROWS - 1) begin
              idx_d   = '0;
              clr_d   = 1'b0;
              state_d = ST_SCR;
            end else begin
              row_d = row_q + 5'd1;
              emit  = 1'b1;
            end
          end
        end
      end
      ST_RDW: begin
        ocell_d = rdata_q;
        emit    = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCR: begin
        raddr   = AW'(32'(idx_q) + COLUMNS);
        state_d = ST_SCW;
      end
      ST_SCW: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = rdata_q;
        idx_d = idx_q + AW'(1);
        state_d = (idx_q == AW'(CELLS - COLUMNS - 1)) ? ST_FILL : ST_SCR;
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = idx_q;
        idx_d = idx_q + AW'(1);
        if (idx_q == AW'(CELLS - 1)) begin
          row_d   = clr_q ? '0 : 5'(ROWS - 1);
          col_d   = '0;
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_d   = ov_q && !pop;
    orow_d = orow_q;
    ocol_d = ocol_q;
    if (emit) begin
      ov_d   = 1'b1;
      orow_d = row_d;
      ocol_d = col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ocell_q <= ocell_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      idx_q   <= '0;
      clr_q   <= 1'b0;
      color_q <= COLOR_RST;
      row_q   <= '0;
      col_q   <= '0;
      ov_q    <= 1'b0;
      orow_q  <= '0;
      ocol_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      clr_q   <= clr_d;
      if (text_color_we_i) begin
        color_q <= text_color_i;
      end
      row_q   <= row_d;
      col_q   <= col_d;
      ov_q    <= ov_d;
      orow_q  <= orow_d;
      ocol_q  <= ocol_d;
    end
  end

  assign empty        = !ov_q;
  assign cell_value_o = ocell_q;
  assign cursor_row_o = orow_q;
  assign cursor_col_o = ocol_q;

endmodule

`default_nettype wire

// ----- hw/rtl/text_console_writer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// once the back end takes an item, its result is registered at the result ports (a cell
// read goes via the read-wait state); throughput: 1 item per cycle for characters, cursor
// sets and control codes while results are popped and no scroll starts; a scroll moves
// rows up and blanks the bottom row, a clear blanks every cell, both by the sequencer; later
// items wait in the command queue; reset: cursor 0,0, color 7, memory init with full high
module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config register
  input  wire logic        text_color_we_i,
  input  wire logic [7:0]  text_color_i,
  // item input queue side
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [6:0]  col_in_i,
  input  wire logic [4:0]  row_in_i,
  // result queue side
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      cell_value_o,
  output logic [4:0]       cursor_row_o,
  output logic [6:0]       cursor_col_o
);
  import tcw_pkg::*;

  // front to back command channel
  logic       cmd_valid;
  cmd_t       cmd;
  back_stat_t stat;

  // front: decodes kind and control characters, range-checks coordinates,
  // holds up to two commands
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .col_in_i    (col_in_i),
    .row_in_i    (row_in_i),
    .stat_i      (stat),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  // back: cursor, screen memory, scroll/clear sequencer and result register
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .text_color_we_i (text_color_we_i),
    .text_color_i    (text_color_i),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .empty           (empty),
    .pop             (pop),
    .cell_value_o    (cell_value_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_col_o    (cursor_col_o)
  );

endmodule

`default_nettype wire
